### rtl/hds_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hds_pkg;

    // Row storage geometry.
    localparam int CELLS = 16;
    localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int CNT_W = $clog2(CELLS + 1);

    // Field widths.
    localparam int TEMP_W    = 32;
    localparam int COEFF_W   = 24;
    localparam int SWEEP_W   = 20;
    localparam int OUT_IDX_W = 6;

    // Arithmetic widths: l + r - 2m needs two extra bits, the product one more
    // for the unsigned coefficient.
    localparam int FRAC_BITS = 24;
    localparam int DIFF_W    = TEMP_W + 2;
    localparam int PROD_W    = DIFF_W + COEFF_W + 1;
    localparam int SHIFT_W   = PROD_W - FRAC_BITS;
    localparam int SUM_W     = SHIFT_W + 1;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_DIFF_COEFF  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_COUNT = 1'b1;
    localparam logic [COEFF_W-1:0] COEFF_RESET = 24'd16777;
    localparam logic [SWEEP_W-1:0] SWEEP_RESET = 20'd20000;

    // Controller states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SWEEP,
        ST_DRAIN,
        ST_OUT,
        ST_FINISH
    } hds_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load_en;
        logic [IDX_W-1:0] load_addr;
        logic             rd_en;
        logic             rd_out;
        logic [IDX_W-1:0] rd_addr;
        logic             src_sel;
        logic [IDX_W-1:0] last_idx;
    } hds_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;
        logic rd_pending;
        logic out_valid;
        logic out_last;
    } hds_stat_t;

endpackage

`default_nettype wire

### rtl/heat_diffusion_stencil_1d.sv
// One-dimensional three-point heat diffusion stencil.
// Input channel (temperature, last_cell; in_valid/in_stall): one cell per cycle
// while loading. The request with last_cell high closes the row; cells past the
// 16-entry capacity are dropped. in_stall stays high from then until the last
// result of the row has been taken.
// Computation: sweep_count Jacobi sweeps between two ping-pong buffers. Each
// sweep of an n-cell row issues n buffer reads through the single shared
// update unit, then drains its read, window, difference and product stages
// before the next sweep reads what this one wrote.
// Result channel (result_value, cell_index, last_result; result_valid/
// result_stall): n results in index order through the registered buffer read
// and the output register, no read starting while one is in flight. A stalled
// result holds in the output register and no further read starts.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data): cfg_ready is always
// high; write only while no row is in progress.
// Reset: diffusion_coeff 16777, sweep_count 20000, an empty row, idle result
// channel; the buffers are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module heat_diffusion_stencil_1d (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic signed [hds_pkg::TEMP_W-1:0]    temperature,
    input  wire logic                                 last_cell,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    output logic signed [hds_pkg::TEMP_W-1:0]         result_value,
    output logic [hds_pkg::OUT_IDX_W-1:0]             cell_index,
    output logic                                      last_result,
    output logic                                      result_valid,
    input  wire logic                                 result_stall,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [hds_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [hds_pkg::CFG_DATA_W-1:0]       cfg_data
);

    logic [hds_pkg::COEFF_W-1:0] diff_coeff_reg;
    logic [hds_pkg::SWEEP_W-1:0] sweep_count_reg;
    hds_pkg::hds_cmd_t           cmd;
    hds_pkg::hds_stat_t          stat;

    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_coeff_reg  <= hds_pkg::COEFF_RESET;
            sweep_count_reg <= hds_pkg::SWEEP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                hds_pkg::REG_DIFF_COEFF:
                begin
                    diff_coeff_reg <= cfg_data[hds_pkg::COEFF_W-1:0];
                end
                hds_pkg::REG_SWEEP_COUNT:
                begin
                    sweep_count_reg <= cfg_data[hds_pkg::SWEEP_W-1:0];
                end
            endcase
        end
    end

    hds_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .last_cell    (last_cell),
        .result_stall (result_stall),
        .sweep_count  (sweep_count_reg),
        .stat         (stat),
        .cmd          (cmd)
    );

    hds_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .diffusion_coeff (diff_coeff_reg),
        .temperature     (temperature),
        .result_stall    (result_stall),
        .stat            (stat),
        .result_value    (result_value),
        .cell_index      (cell_index),
        .last_result     (last_result),
        .result_valid    (result_valid)
    );

endmodule

`default_nettype wire

### rtl/hds_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module hds_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         last_cell,
    input  wire logic                         result_stall,
    input  wire logic [hds_pkg::SWEEP_W-1:0]  sweep_count,
    input  wire hds_pkg::hds_stat_t           stat,
    output hds_pkg::hds_cmd_t                 cmd
);

    hds_pkg::hds_state_t state_reg, state_next;
    logic [hds_pkg::CNT_W-1:0]   loaded_cnt_reg, loaded_cnt_next;
    logic [hds_pkg::IDX_W-1:0]   last_idx_reg, last_idx_next;
    logic [hds_pkg::IDX_W-1:0]   addr_cnt_reg, addr_cnt_next;
    logic [hds_pkg::SWEEP_W-1:0] sweep_cnt_reg, sweep_cnt_next;
    logic                        src_sel_reg, src_sel_next;

    logic in_accept;
    logic row_full;
    logic out_room;
    logic sweeps_done;

    assign in_accept   = (state_reg == hds_pkg::ST_LOAD) && in_valid;
    assign row_full    = (loaded_cnt_reg == hds_pkg::CNT_W'(hds_pkg::CELLS));
    assign sweeps_done = ((sweep_cnt_reg + hds_pkg::SWEEP_W'(1)) == sweep_count);

    // A result read may start when nothing is in flight and the output register
    // is empty or is being taken in this cycle.
    assign out_room = !stat.rd_pending && (!stat.out_valid || !result_stall);

    // Next state and counter updates.
    always_comb
    begin
        state_next      = state_reg;
        loaded_cnt_next = loaded_cnt_reg;
        last_idx_next   = last_idx_reg;
        addr_cnt_next   = addr_cnt_reg;
        sweep_cnt_next  = sweep_cnt_reg;
        src_sel_next    = src_sel_reg;
        unique case (state_reg)
            hds_pkg::ST_LOAD:
            begin
                if (in_accept)
                begin
                    if (!row_full)
                    begin
                        loaded_cnt_next = loaded_cnt_reg + hds_pkg::CNT_W'(1);
                    end
                    if (last_cell)
                    begin
                        // The closing request fixes the row length.
                        last_idx_next   = row_full ? hds_pkg::IDX_W'(hds_pkg::CELLS - 1)
                                                   : loaded_cnt_reg[hds_pkg::IDX_W-1:0];
                        loaded_cnt_next = '0;
                        addr_cnt_next   = '0;
                        sweep_cnt_next  = '0;
                        state_next      = (sweep_count == '0) ? hds_pkg::ST_OUT
                                                              : hds_pkg::ST_SWEEP;
                    end
                end
            end
            hds_pkg::ST_SWEEP:
            begin
                if (addr_cnt_reg == last_idx_reg)
                begin
                    addr_cnt_next = '0;
                    state_next    = hds_pkg::ST_DRAIN;
                end
                else
                begin
                    addr_cnt_next = addr_cnt_reg + hds_pkg::IDX_W'(1);
                end
            end
            hds_pkg::ST_DRAIN:
            begin
                if (!stat.busy)
                begin
                    src_sel_next = !src_sel_reg;
                    if (sweeps_done)
                    begin
                        sweep_cnt_next = '0;
                        state_next     = hds_pkg::ST_OUT;
                    end
                    else
                    begin
                        sweep_cnt_next = sweep_cnt_reg + hds_pkg::SWEEP_W'(1);
                        state_next     = hds_pkg::ST_SWEEP;
                    end
                end
            end
            hds_pkg::ST_OUT:
            begin
                if (out_room)
                begin
                    if (addr_cnt_reg == last_idx_reg)
                    begin
                        addr_cnt_next = '0;
                        state_next    = hds_pkg::ST_FINISH;
                    end
                    else
                    begin
                        addr_cnt_next = addr_cnt_reg + hds_pkg::IDX_W'(1);
                    end
                end
            end
            hds_pkg::ST_FINISH:
            begin
                if (stat.out_valid && !result_stall && stat.out_last)
                begin
                    src_sel_next = 1'b0;
                    state_next   = hds_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = hds_pkg::ST_LOAD;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        in_stall      = 1'b1;
        cmd.load_en   = 1'b0;
        cmd.load_addr = loaded_cnt_reg[hds_pkg::IDX_W-1:0];
        cmd.rd_en     = 1'b0;
        cmd.rd_out    = 1'b0;
        cmd.rd_addr   = addr_cnt_reg;
        cmd.src_sel   = src_sel_reg;
        cmd.last_idx  = last_idx_reg;
        unique case (state_reg)
            hds_pkg::ST_LOAD:
            begin
                in_stall    = 1'b0;
                cmd.load_en = in_valid && !row_full;
            end
            hds_pkg::ST_SWEEP:
            begin
                cmd.rd_en = 1'b1;
            end
            hds_pkg::ST_OUT:
            begin
                cmd.rd_en  = out_room;
                cmd.rd_out = 1'b1;
            end
            hds_pkg::ST_DRAIN,
            hds_pkg::ST_FINISH:
            begin
                cmd.rd_en = 1'b0;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    // State and counter registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= hds_pkg::ST_LOAD;
            loaded_cnt_reg <= '0;
            last_idx_reg   <= '0;
            addr_cnt_reg   <= '0;
            sweep_cnt_reg  <= '0;
            src_sel_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            loaded_cnt_reg <= loaded_cnt_next;
            last_idx_reg   <= last_idx_next;
            addr_cnt_reg   <= addr_cnt_next;
            sweep_cnt_reg  <= sweep_cnt_next;
            src_sel_reg    <= src_sel_next;
        end
    end

`ifndef SYNTHESIS
    // The fill count never passes the row capacity.
    a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
        loaded_cnt_reg <= hds_pkg::CNT_W'(hds_pkg::CELLS))
        else $error("loaded count exceeds row capacity");

    // Reads never go past the end of the current row.
    a_read_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (addr_cnt_reg <= last_idx_reg))
        else $error("read address beyond the row");
`endif

endmodule

`default_nettype wire

### rtl/hds_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module hds_datapath (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hds_pkg::hds_cmd_t                   cmd,
    input  wire logic [hds_pkg::COEFF_W-1:0]         diffusion_coeff,
    input  wire logic signed [hds_pkg::TEMP_W-1:0]   temperature,
    input  wire logic                                result_stall,
    output hds_pkg::hds_stat_t                       stat,
    output logic signed [hds_pkg::TEMP_W-1:0]        result_value,
    output logic [hds_pkg::OUT_IDX_W-1:0]            cell_index,
    output logic                                     last_result,
    output logic                                     result_valid
);

    // Ping-pong row buffers.
    logic [hds_pkg::TEMP_W-1:0] buf_a_mem [hds_pkg::CELLS];
    logic [hds_pkg::TEMP_W-1:0] buf_b_mem [hds_pkg::CELLS];
    logic [hds_pkg::TEMP_W-1:0] buf_a_q_reg;
    logic [hds_pkg::TEMP_W-1:0] buf_b_q_reg;

    // Read stage.
    logic                       rd_vld_reg;
    logic                       rd_out_reg;
    logic [hds_pkg::IDX_W-1:0]  rd_idx_reg;
    logic signed [hds_pkg::TEMP_W-1:0] rd_data;

    // Neighbor window and launch control.
    logic signed [hds_pkg::TEMP_W-1:0] prv_reg;
    logic signed [hds_pkg::TEMP_W-1:0] cur_reg;
    logic                              flush_pend_reg;
    logic [hds_pkg::IDX_W-1:0]         lidx_reg;
    logic                              sweep_beat;
    logic                              launch;
    logic signed [hds_pkg::TEMP_W-1:0] win_l;
    logic signed [hds_pkg::TEMP_W-1:0] win_m;
    logic signed [hds_pkg::TEMP_W-1:0] win_r;
    logic signed [hds_pkg::DIFF_W-1:0] diff;

    // Difference stage.
    logic                              s1_vld_reg;
    logic signed [hds_pkg::DIFF_W-1:0] s1_d_reg;
    logic signed [hds_pkg::TEMP_W-1:0] s1_m_reg;
    logic [hds_pkg::IDX_W-1:0]         s1_idx_reg;

    // Product stage.
    logic                              s2_vld_reg;
    logic signed [hds_pkg::PROD_W-1:0] s2_p_reg;
    logic signed [hds_pkg::TEMP_W-1:0] s2_m_reg;
    logic [hds_pkg::IDX_W-1:0]         s2_idx_reg;

    // Update result.
    logic signed [hds_pkg::SHIFT_W-1:0] shifted;
    logic signed [hds_pkg::SUM_W-1:0]   upd_sum;
    logic [hds_pkg::TEMP_W-1:0]         upd_val;

    // Output register.
    logic                              out_valid_reg;
    logic signed [hds_pkg::TEMP_W-1:0] out_value_reg;
    logic [hds_pkg::IDX_W-1:0]         out_idx_reg;
    logic                              out_last_reg;

    // Buffer A takes the loaded row and the odd sweeps' results.
    always_ff @(posedge clk)
    begin
        if (cmd.load_en)
        begin
            buf_a_mem[cmd.load_addr] <= temperature;
        end
        else if (s2_vld_reg && cmd.src_sel)
        begin
            buf_a_mem[s2_idx_reg] <= upd_val;
        end
        buf_a_q_reg <= buf_a_mem[cmd.rd_addr];
    end

    // Buffer B takes the even sweeps' results.
    always_ff @(posedge clk)
    begin
        if (s2_vld_reg && !cmd.src_sel)
        begin
            buf_b_mem[s2_idx_reg] <= upd_val;
        end
        buf_b_q_reg <= buf_b_mem[cmd.rd_addr];
    end

    assign rd_data = cmd.src_sel ? buf_b_q_reg : buf_a_q_reg;

    // Read tracking.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg <= 1'b0;
            rd_out_reg <= 1'b0;
            rd_idx_reg <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.rd_en;
            rd_out_reg <= cmd.rd_out;
            rd_idx_reg <= cmd.rd_addr;
        end
    end

    // A cell launches once its right neighbor arrives; the last cell launches from
    // flush_pend_reg, set by the final read beat, with itself standing in as the right side.
    assign sweep_beat = rd_vld_reg && !rd_out_reg;
    assign launch     = flush_pend_reg || (sweep_beat && (rd_idx_reg != '0));
    assign win_m      = cur_reg;
    assign win_l      = (lidx_reg == '0) ? cur_reg : prv_reg;
    assign win_r      = flush_pend_reg ? cur_reg : rd_data;
    assign diff       = {{2{win_l[hds_pkg::TEMP_W-1]}}, win_l}
                      + {{2{win_r[hds_pkg::TEMP_W-1]}}, win_r}
                      - {win_m[hds_pkg::TEMP_W-1], win_m, 1'b0};

    // Window control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_pend_reg <= 1'b0;
            lidx_reg       <= '0;
        end
        else
        begin
            flush_pend_reg <= sweep_beat && (rd_idx_reg == cmd.last_idx);
            if (launch)
            begin
                lidx_reg <= flush_pend_reg ? '0 : (lidx_reg + hds_pkg::IDX_W'(1));
            end
        end
    end

    // Window data.
    always_ff @(posedge clk)
    begin
        if (sweep_beat)
        begin
            prv_reg <= cur_reg;
            cur_reg <= rd_data;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= launch;
            s2_vld_reg <= s1_vld_reg;
        end
    end

    // Difference and product stages.
    always_ff @(posedge clk)
    begin
        s1_d_reg   <= diff;
        s1_m_reg   <= win_m;
        s1_idx_reg <= lidx_reg;
        s2_p_reg   <= hds_pkg::PROD_W'(s1_d_reg)
                    * hds_pkg::PROD_W'($signed({1'b0, diffusion_coeff}));
        s2_m_reg   <= s1_m_reg;
        s2_idx_reg <= s1_idx_reg;
    end

    // Floor shift, add the center value and saturate to 32 bits.
    always_comb
    begin
        shifted = s2_p_reg[hds_pkg::PROD_W-1:hds_pkg::FRAC_BITS];
        upd_sum = {{(hds_pkg::SUM_W - hds_pkg::TEMP_W){s2_m_reg[hds_pkg::TEMP_W-1]}}, s2_m_reg}
                + {shifted[hds_pkg::SHIFT_W-1], shifted};
        if (upd_sum[hds_pkg::SUM_W-1:hds_pkg::TEMP_W-1] == '0
            || upd_sum[hds_pkg::SUM_W-1:hds_pkg::TEMP_W-1] == '1)
        begin
            upd_val = upd_sum[hds_pkg::TEMP_W-1:0];
        end
        else if (upd_sum[hds_pkg::SUM_W-1])
        begin
            upd_val = {1'b1, {(hds_pkg::TEMP_W-1){1'b0}}};
        end
        else
        begin
            upd_val = {1'b0, {(hds_pkg::TEMP_W-1){1'b1}}};
        end
    end

    // Output register: loaded from a result read, cleared when taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (rd_vld_reg && rd_out_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg && rd_out_reg)
        begin
            out_value_reg <= rd_data;
            out_idx_reg   <= rd_idx_reg;
            out_last_reg  <= (rd_idx_reg == cmd.last_idx);
        end
    end

    assign result_valid = out_valid_reg;
    assign result_value = out_value_reg;
    assign cell_index   = hds_pkg::OUT_IDX_W'(out_idx_reg);
    assign last_result  = out_last_reg;

    // Status to the controller.
    assign stat.busy       = rd_vld_reg || flush_pend_reg || s1_vld_reg || s2_vld_reg;
    assign stat.rd_pending = rd_vld_reg;
    assign stat.out_valid  = out_valid_reg;
    assign stat.out_last   = out_last_reg;

`ifndef SYNTHESIS
    // A waiting result is never overwritten by the next read.
    a_out_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && result_stall) |-> !(rd_vld_reg && rd_out_reg))
        else $error("pending result overwritten");

    // The last-cell launch never collides with a sweep read beat.
    a_flush_alone: assert property (@(posedge clk) disable iff (!rst_n)
        flush_pend_reg |-> !sweep_beat)
        else $error("flush launch collides with a read beat");

    // Updates are written only inside the current row.
    a_write_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> (s2_idx_reg <= cmd.last_idx))
        else $error("update written beyond the row");
`endif

endmodule

`default_nettype wire

### sim/tb_heat_diffusion_stencil_1d.sv
`timescale 1ns / 1ps

module tb_heat_diffusion_stencil_1d;
    import hds_pkg::*;

    localparam int  SETTLE_CYCLES = 8;
    localparam int  END_CYCLES    = 40;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  RANDOM_CELLS  = 330;
    localparam longint TIMEOUT_NS = 12_000_000;

    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 32'sh8000_0000;
    localparam logic [COEFF_W-1:0]       COEFF_MAX = '1;

    // Result pacing patterns and temperature flavors for random rows.
    typedef enum int {PACE_FREE, PACE_LIGHT, PACE_HEAVY, PACE_PERIODIC} pace_mode_t;
    typedef enum int {TEMPS_FULL, TEMPS_SMALL, TEMPS_EXTREME, TEMPS_MIXED} temp_style_t;

    typedef struct {
        logic signed [TEMP_W-1:0] value;
        logic [OUT_IDX_W-1:0]     index;
        logic                     last;
    } cell_result_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic signed [TEMP_W-1:0]    temperature = '0;
    logic                        last_cell = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_stall;
    logic signed [TEMP_W-1:0]    result_value;
    logic [OUT_IDX_W-1:0]        cell_index;
    logic                        last_result;
    logic                        result_valid;
    logic                        result_stall = 1'b0;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index = REG_DIFF_COEFF;
    logic [CFG_DATA_W-1:0]       cfg_data = '0;

    // Predictor state: the row being loaded, the two sweep buffers and the registers.
    logic signed [TEMP_W-1:0]    row_buf [2][CELLS];
    int                          cells_held = 0;
    logic [COEFF_W-1:0]          coeff_reg = COEFF_RESET;
    logic [SWEEP_W-1:0]          sweeps_reg = SWEEP_RESET;
    cell_result_t                expected_cells [$];

    // Sender pacing and receiver hold-off request.
    int                          burst_left = 0;
    bit                          gaps_on = 1'b1;
    bit                          hold_request = 1'b0;

    int                          errors = 0;
    int                          results_checked = 0;
    int                          cells_stored = 0;
    int                          rows_closed = 0;
    int                          settings_used = 0;
    int                          holds_done = 0;

    heat_diffusion_stencil_1d uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .temperature  (temperature),
        .last_cell    (last_cell),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .result_value (result_value),
        .cell_index   (cell_index),
        .last_result  (last_result),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #2 clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d results outstanding", $time, expected_cells.size());
        $display("tb_heat_diffusion_stencil_1d failed");
        $finish;
    end

    // One Jacobi update of a cell: mid plus the weighted Laplacian, floored and saturated.
    function automatic logic signed [TEMP_W-1:0] diffuse_cell(
        input logic signed [TEMP_W-1:0] west,
        input logic signed [TEMP_W-1:0] here,
        input logic signed [TEMP_W-1:0] east
    );
        longint weight;
        longint grad;
        longint next_val;
        weight = longint'(coeff_reg);
        grad = longint'(west) + longint'(east) - 2 * longint'(here);
        next_val = longint'(here) + ((grad * weight) >>> FRAC_BITS);
        if (next_val > longint'(TEMP_MAX))
            next_val = longint'(TEMP_MAX);
        if (next_val < longint'(TEMP_MIN))
            next_val = longint'(TEMP_MIN);
        return next_val[TEMP_W-1:0];
    endfunction

    // Store an accepted cell; a closing request runs the sweeps and queues the row.
    task automatic absorb_cell(input logic signed [TEMP_W-1:0] temp, input logic closes);
        int n;
        int s;
        int i;
        int src;
        logic signed [TEMP_W-1:0] mid;
        logic signed [TEMP_W-1:0] west;
        logic signed [TEMP_W-1:0] east;
        cell_result_t res;
        if (cells_held < CELLS)
        begin
            row_buf[0][cells_held] = temp;
            cells_held++;
            cells_stored++;
        end
        if (closes)
        begin
            n = cells_held;
            for (s = 0; s < int'(sweeps_reg); s++)
            begin
                src = s % 2;
                for (i = 0; i < n; i++)
                begin
                    mid = row_buf[src][i];
                    west = (i > 0) ? row_buf[src][i-1] : mid;
                    east = (i + 1 < n) ? row_buf[src][i+1] : mid;
                    row_buf[1-src][i] = diffuse_cell(west, mid, east);
                end
            end
            src = int'(sweeps_reg[0]);
            for (i = 0; i < n; i++)
            begin
                res.value = row_buf[src][i];
                res.index = i[OUT_IDX_W-1:0];
                res.last = (i + 1 == n);
                expected_cells.push_back(res);
            end
            cells_held = 0;
            rows_closed++;
        end
    endtask

    // Offer one cell request, with random gaps between bursts, and wait for acceptance.
    task automatic send_cell(input logic signed [TEMP_W-1:0] temp, input logic closes);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        temperature <= temp;
        last_cell <= closes;
        do
            @(posedge clk);
        while (in_stall);
        absorb_cell(temp, closes);
    endtask

    // Drop valid, wait for every queued result, then let the block settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_cells.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back; sweep data may carry junk above bit 19.
    task automatic program_regs(input logic [CFG_DATA_W-1:0] coeff_data,
                                input logic [CFG_DATA_W-1:0] sweep_data);
        cfg_valid <= 1'b1;
        cfg_index <= REG_DIFF_COEFF;
        cfg_data <= coeff_data;
        do
            @(posedge clk);
        while (!cfg_ready);
        coeff_reg = coeff_data[COEFF_W-1:0];
        cfg_index <= REG_SWEEP_COUNT;
        cfg_data <= sweep_data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sweeps_reg = sweep_data[SWEEP_W-1:0];
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic signed [TEMP_W-1:0] pick_temperature(input temp_style_t style);
        temp_style_t flavor;
        int pick;
        flavor = style;
        if (flavor == TEMPS_MIXED)
            flavor = temp_style_t'($urandom_range(0, 2));
        case (flavor)
            TEMPS_SMALL:
                return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
            TEMPS_EXTREME:
            begin
                pick = $urandom_range(0, 4);
                case (pick)
                    0: return TEMP_MAX;
                    1: return TEMP_MIN;
                    2: return '0;
                    3: return -32'sd1;
                    default: return 32'sd1;
                endcase
            end
            default:
                return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coeff();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return COEFF_MAX;
            2: return CFG_DATA_W'($urandom_range(0, 65535));
            3: return CFG_DATA_W'($urandom_range(24'h700000, 24'h900000));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_sweep_data();
        logic [SWEEP_W-1:0] count;
        logic [3:0] junk;
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            count = '0;
        else if (pick == 1)
            count = 20'd1;
        else if (pick == 2)
            count = SWEEP_W'($urandom_range(40, 150));
        else
            count = SWEEP_W'($urandom_range(1, 8));
        junk = 4'($urandom);
        return {junk, count};
    endfunction

    // Mostly in-range rows, with single cells, full rows and overlong rows mixed in.
    function automatic int pick_row_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 8)
            return $urandom_range(CELLS + 1, CELLS + 6);
        else if (pick < 16)
            return CELLS;
        else if (pick < 26)
            return 1;
        else
            return $urandom_range(2, CELLS - 1);
    endfunction

    task automatic send_row(input int n, input temp_style_t style);
        int i;
        for (i = 0; i < n; i++)
            send_cell(pick_temperature(style), i == n - 1);
    endtask

    // Result checker: each taken result against the oldest expected cell.
    always @(posedge clk)
    begin : result_check
        cell_result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_cells.size() == 0)
            begin
                $display("%0t: unexpected result value %h index %0d last %b", $time,
                         result_value, cell_index, last_result);
                errors++;
            end
            else
            begin
                want = expected_cells.pop_front();
                results_checked++;
                if (result_value !== want.value)
                begin
                    $display("%0t: result_value expected %h actual %h", $time,
                             want.value, result_value);
                    errors++;
                end
                if (cell_index !== want.index)
                begin
                    $display("%0t: cell_index expected %0d actual %0d", $time,
                             want.index, cell_index);
                    errors++;
                end
                if (last_result !== want.last)
                begin
                    $display("%0t: last_result expected %b actual %b", $time,
                             want.last, last_result);
                    errors++;
                end
            end
        end
    end

    // Receiver pacing: random stall patterns, plus a long hold-off on request.
    initial
    begin : receiver_pacing
        pace_mode_t mode;
        int mode_left;
        int hold_left;
        mode = PACE_FREE;
        mode_left = 0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
                holds_done++;
            end
            if (mode_left == 0)
            begin
                mode = pace_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    PACE_LIGHT: result_stall <= ($urandom_range(0, 99) < 30);
                    PACE_HEAVY: result_stall <= ($urandom_range(0, 99) < 75);
                    PACE_PERIODIC: result_stall <= mode_left[2];
                    default: result_stall <= 1'b0;
                endcase
            end
        end
    end

    // Registers as they come out of reset: a slow, gentle diffusion over 20000 sweeps.
    task automatic test_reset_defaults();
        send_cell(32'sh0064_0000, 1'b0);
        send_cell(-32'sh0032_0000, 1'b0);
        send_cell(32'sh0000_8000, 1'b1);
        wait_idle();
    endtask

    // A lone cell is its own neighbor on both sides and never changes.
    task automatic test_single_cell();
        program_regs(COEFF_MAX, 24'd5);
        send_cell(TEMP_MIN, 1'b1);
        wait_idle();
    endtask

    // Largest sweep count is written, then a count whose low 20 bits are zero.
    task automatic test_zero_sweeps();
        program_regs(COEFF_MAX, 24'hFF_FFFF);
        wait_idle();
        program_regs(24'h80_0000, 24'hF0_0000);
        send_cell(32'sd1, 1'b0);
        send_cell(TEMP_MIN, 1'b0);
        send_cell(TEMP_MAX, 1'b1);
        wait_idle();
    endtask

    // Alternating extremes with a full weight drive the sum past both rails.
    task automatic test_saturation();
        program_regs(COEFF_MAX, 24'd1);
        send_cell(TEMP_MAX, 1'b0);
        send_cell(TEMP_MIN, 1'b0);
        send_cell(TEMP_MAX, 1'b1);
        send_cell(TEMP_MIN, 1'b0);
        send_cell(TEMP_MAX, 1'b0);
        send_cell(TEMP_MIN, 1'b1);
        wait_idle();
    endtask

    // With no neighbor weight the row comes back unchanged.
    task automatic test_zero_coeff();
        program_regs('0, 24'd3);
        send_cell(32'sh1234_5678, 1'b0);
        send_cell(-32'sd1, 1'b1);
        wait_idle();
    endtask

    // Long receiver hold-off while full rows keep coming, then a full drain pause.
    task automatic test_backpressure();
        int r;
        program_regs(pick_coeff(), 24'd2);
        gaps_on = 1'b0;
        hold_request = 1'b1;
        for (r = 0; r < 3; r++)
            send_row(CELLS, TEMPS_MIXED);
        wait_idle();
        send_row($urandom_range(2, CELLS), TEMPS_FULL);
        gaps_on = 1'b1;
        wait_idle();
    endtask

    // Random phases: new register settings, then a batch of random rows.
    task automatic test_random_rows();
        int goal;
        int phase_goal;
        goal = cells_stored + RANDOM_CELLS;
        while (cells_stored < goal)
        begin
            wait_idle();
            program_regs(pick_coeff(), pick_sweep_data());
            gaps_on = ($urandom_range(0, 3) != 0);
            phase_goal = cells_stored + $urandom_range(30, 60);
            while (cells_stored < phase_goal)
            begin
                send_row(pick_row_length(), temp_style_t'($urandom_range(0, 3)));
                if ($urandom_range(0, 9) == 0)
                    wait_idle();
            end
        end
        wait_idle();
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_single_cell();
        test_zero_sweeps();
        test_saturation();
        test_zero_coeff();
        test_backpressure();
        test_random_rows();

        repeat (END_CYCLES) @(posedge clk);
        $display("Run covered %0d rows, %0d stored cells, %0d checked results, %0d settings.",
                 rows_closed, cells_stored, results_checked, settings_used);
        $display("Included reset defaults, lone and overlong rows, zero sweeps, rail clamps, %0d hold-offs.",
                 holds_done);
        if (errors == 0 && expected_cells.size() == 0)
            $display("tb_heat_diffusion_stencil_1d passed");
        else
            $display("tb_heat_diffusion_stencil_1d failed");
        $finish;
    end

endmodule

### sim.f
rtl/hds_pkg.sv
rtl/hds_ctrl.sv
rtl/hds_datapath.sv
rtl/heat_diffusion_stencil_1d.sv
sim/tb_heat_diffusion_stencil_1d.sv
